FILE: sv/tev_pkg.sv
package tev_pkg;

    localparam int STAGES    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_ZERO     = 3'd0,
        CFG_COLOR_ONE      = 3'd1,
        CFG_KONST_COLOR    = 3'd2,
        CFG_KONST_ALPHA    = 3'd3,
        CFG_TINT_COLOR     = 3'd4,
        CFG_COMBINE_MODE   = 3'd5,
        CFG_ALPHA_AS_COLOR = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUANT   = 2'd1,
        MODE_SPARKLE = 2'd2,
        MODE_GLOW    = 2'd3
    } combine_mode_t;

    typedef struct packed {
        logic [23:0]   color_zero;
        logic [23:0]   color_one;
        logic [23:0]   konst_color;
        logic [7:0]    konst_alpha;
        logic [23:0]   tint_color;
        combine_mode_t combine_mode;
        logic          alpha_as_color;
    } cfg_t;

    typedef struct packed {
        logic [STAGES-1:0] en;
    } pipe_ctrl_t;

    typedef logic [255:0][7:0] lut256_t;
    typedef logic [63:0][7:0]  lut64_t;

    // 255^3
    localparam logic [31:0] DIV_CUBE = 32'd16581375;

    // round(255 * (a/255)^0.6): largest y with (2y-1)^5 <= 32*65025*a^3
    function automatic lut256_t build_sparkle();
        lut256_t     lut;
        logic [63:0] target;
        logic [63:0] x;
        logic [63:0] p;
        logic [7:0]  y;
        logic [7:0]  cand;
        for (int a = 0; a < 256; a++) begin
            target = 64'd2080800 * 64'(a) * 64'(a) * 64'(a);
            y = 8'd0;
            for (int b = 7; b >= 0; b--) begin
                cand = y | 8'(1 << b);
                x = 64'(2) * 64'(cand) - 64'd1;
                p = x * x * x * x * x;
                if (p <= target) begin
                    y = cand;
                end
            end
            lut[a] = y;
        end
        return lut;
    endfunction

    // round(q * 255 / 63)
    function automatic lut64_t build_q6();
        lut64_t lut;
        for (int q = 0; q < 64; q++) begin
            lut[q] = 8'((170 * q + 21) / 42);
        end
        return lut;
    endfunction

    localparam lut256_t SPARKLE_LUT = build_sparkle();
    localparam lut64_t  Q6_LUT      = build_q6();

endpackage

FILE: sv/tev_cfg.sv
module tev_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tev_pkg::CFG_DAT_W-1:0]    cfg_data,
    output tev_pkg::cfg_t                    cfg
);
    import tev_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLOR_ZERO:     cfg_next.color_zero     = cfg_data[23:0];
                CFG_COLOR_ONE:      cfg_next.color_one      = cfg_data[23:0];
                CFG_KONST_COLOR:    cfg_next.konst_color    = cfg_data[23:0];
                CFG_KONST_ALPHA:    cfg_next.konst_alpha    = cfg_data[7:0];
                CFG_TINT_COLOR:     cfg_next.tint_color     = cfg_data[23:0];
                CFG_COMBINE_MODE:   cfg_next.combine_mode   = combine_mode_t'(cfg_data[1:0]);
                CFG_ALPHA_AS_COLOR: cfg_next.alpha_as_color = cfg_data[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_zero     <= 24'hFFFFFF;
            cfg_reg.color_one      <= 24'h000000;
            cfg_reg.konst_color    <= 24'hFFFFFF;
            cfg_reg.konst_alpha    <= 8'hFF;
            cfg_reg.tint_color     <= 24'hFFFFFF;
            cfg_reg.combine_mode   <= MODE_PLAIN;
            cfg_reg.alpha_as_color <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/tev_color_lane.sv
module tev_color_lane (
    input  logic                  clk,
    input  tev_pkg::pipe_ctrl_t   ctrl,
    input  logic                  plain_mode,
    input  logic                  alpha_as_color,
    input  logic [7:0]            c0,
    input  logic [7:0]            c1,
    input  logic [7:0]            kc,
    input  logic [7:0]            g,
    input  logic [7:0]            tex_chan,
    input  logic [7:0]            tex_alpha,
    output logic [7:0]            out_chan
);
    import tev_pkg::*;

    // stage 1
    logic [7:0]         t;
    logic [8:0]         tcq;
    logic signed [9:0]  diff;
    logic [16:0]        s1_s_next;
    logic [15:0]        s1_gc0_next;
    logic signed [18:0] s1_lerp_next;
    logic [16:0]        s1_s_reg;
    logic [15:0]        s1_gc0_reg;
    logic signed [18:0] s1_lerp_reg;

    // stage 2
    logic [10:0]        m_raw;
    logic [7:0]         m;
    logic [31:0]        s2_n_reg;
    logic [15:0]        s2_qp_reg;

    // stage 3
    logic [31:0]        y;
    logic [24:0]        est_prod;
    logic [15:0]        qv;
    logic [15:0]        qsum;
    logic [31:0]        s3_y_reg;
    logic [7:0]         s3_qe_reg;
    logic [7:0]         s3_qout_reg;

    // stage 4
    logic [31:0]        s4_y_reg;
    logic [31:0]        s4_prod_reg;
    logic [7:0]         s4_qe_reg;
    logic [7:0]         s4_qout_reg;

    // stage 5
    logic [31:0]        rem;
    logic [7:0]         q_plain;
    logic [7:0]         s5_out_next;
    logic [7:0]         s5_out_reg;

    always_comb
    begin
        t            = alpha_as_color ? tex_alpha : tex_chan;
        s1_s_next    = 17'(c1) * 17'(8'd255 - t) + 17'(kc) * 17'(t);
        s1_gc0_next  = 16'(g) * 16'(c0);
        tcq          = {1'b0, tex_chan} + {8'b0, tex_chan[7]};
        diff         = $signed({2'b0, c0}) - $signed({2'b0, c1});
        s1_lerp_next = $signed({3'b0, c1, 8'h80}) + 19'(diff) * $signed({10'b0, tcq});
    end

    always_comb
    begin
        m_raw = s1_lerp_reg[18:8];
        m     = (m_raw > 11'd255) ? 8'd255 : m_raw[7:0];
    end

    always_comb
    begin
        y        = s2_n_reg + 32'd8290687;
        est_prod = 25'(y[31:16]) * 25'd259;
        qv       = s2_qp_reg + 16'd127;
        qsum     = qv + {8'b0, qv[15:8]} + 16'd1;
    end

    always_comb
    begin
        rem = s4_y_reg - s4_prod_reg;
        if (rem >= {DIV_CUBE[30:0], 1'b0})
        begin
            q_plain = s4_qe_reg + 8'd2;
        end
        else if (rem >= DIV_CUBE)
        begin
            q_plain = s4_qe_reg + 8'd1;
        end
        else
        begin
            q_plain = s4_qe_reg;
        end
        s5_out_next = plain_mode ? q_plain : s4_qout_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_s_reg    <= s1_s_next;
            s1_gc0_reg  <= s1_gc0_next;
            s1_lerp_reg <= s1_lerp_next;
        end
        if (ctrl.en[1])
        begin
            s2_n_reg  <= 32'(s1_gc0_reg) * 32'(s1_s_reg);
            s2_qp_reg <= 16'(m) * 16'(g);
        end
        if (ctrl.en[2])
        begin
            s3_y_reg    <= y;
            s3_qe_reg   <= est_prod[23:16];
            s3_qout_reg <= qsum[15:8];
        end
        if (ctrl.en[3])
        begin
            s4_y_reg    <= s3_y_reg;
            s4_prod_reg <= 32'(s3_qe_reg) * DIV_CUBE;
            s4_qe_reg   <= s3_qe_reg;
            s4_qout_reg <= s3_qout_reg;
        end
        if (ctrl.en[4])
        begin
            s5_out_reg <= s5_out_next;
        end
    end

    assign out_chan = s5_out_reg;

endmodule

FILE: sv/tev_alpha_path.sv
module tev_alpha_path (
    input  logic                    clk,
    input  tev_pkg::pipe_ctrl_t     ctrl,
    input  tev_pkg::combine_mode_t  combine_mode,
    input  logic [7:0]              konst_alpha,
    input  logic [7:0]              tex_alpha,
    output logic [7:0]              out_alpha
);
    import tev_pkg::*;

    logic [15:0] s1_p_reg;
    logic [7:0]  s1_a_reg;
    logic [21:0] s2_v_reg;
    logic [7:0]  s2_a_reg;
    logic [5:0]  qe;
    logic [21:0] rem;
    logic [5:0]  s3_q_next;
    logic [5:0]  s3_q_reg;
    logic [7:0]  s3_sp_reg;
    logic [7:0]  s3_a_reg;
    logic [7:0]  s4_out_next;
    logic [7:0]  s4_out_reg;
    logic [7:0]  s5_out_reg;

    always_comb
    begin
        qe  = s2_v_reg[21:16];
        rem = s2_v_reg - 22'(qe) * 22'd65025;
        s3_q_next = (rem >= 22'd65025) ? qe + 6'd1 : qe;
    end

    always_comb
    begin
        case (combine_mode)
            MODE_QUANT:   s4_out_next = Q6_LUT[s3_q_reg];
            MODE_SPARKLE: s4_out_next = s3_sp_reg;
            default:      s4_out_next = s3_a_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_p_reg <= 16'(tex_alpha) * 16'(konst_alpha);
            s1_a_reg <= tex_alpha;
        end
        if (ctrl.en[1])
        begin
            s2_v_reg <= 22'(s1_p_reg) * 22'd63 + 22'd32512;
            s2_a_reg <= s1_a_reg;
        end
        if (ctrl.en[2])
        begin
            s3_q_reg  <= s3_q_next;
            s3_sp_reg <= SPARKLE_LUT[s2_a_reg];
            s3_a_reg  <= s2_a_reg;
        end
        if (ctrl.en[3])
        begin
            s4_out_reg <= s4_out_next;
        end
        if (ctrl.en[4])
        begin
            s5_out_reg <= s4_out_reg;
        end
    end

    assign out_alpha = s5_out_reg;

endmodule

FILE: sv/tev_texture_color_combiner.sv
// Pipeline: 5 register stages; out_valid rises when an accepted texel reaches the last stage.
// Throughput: one texel per cycle; a stalled output holds each occupied stage that has no
// empty stage after it; empty stages and the other occupied stages still advance.
// The longest stage is the 16x17 product of the plain-mode blend term.
// Reset clears all stage valid bits and loads the configuration reset values;
// data registers are not reset.
module tev_texture_color_combiner (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tev_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       tex_red,
    input  logic [7:0]                       tex_green,
    input  logic [7:0]                       tex_blue,
    input  logic [7:0]                       tex_alpha,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [7:0]                       out_red,
    output logic [7:0]                       out_green,
    output logic [7:0]                       out_blue,
    output logic [7:0]                       out_alpha
);
    import tev_pkg::*;

    cfg_t              cfg;
    pipe_ctrl_t        ctrl;
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              plain_mode;
    logic [2:0][7:0]   tex_rgb;
    logic [2:0][7:0]   out_rgb;

    tev_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    always_comb
    begin
        ctrl.en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            ctrl.en[i] = !valid_reg[i] || ctrl.en[i+1];
        end
        valid_next = valid_reg;
        if (ctrl.en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (ctrl.en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = ctrl.en[0];
    assign out_valid  = valid_reg[STAGES-1];
    assign plain_mode = (cfg.combine_mode == MODE_PLAIN);

    // lane 0 red, 1 green, 2 blue; packed colors hold red in the top byte
    assign tex_rgb[0] = tex_red;
    assign tex_rgb[1] = tex_green;
    assign tex_rgb[2] = tex_blue;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        tev_color_lane u_lane (
            .clk            (clk),
            .ctrl           (ctrl),
            .plain_mode     (plain_mode),
            .alpha_as_color (cfg.alpha_as_color),
            .c0             (cfg.color_zero[16-8*k +: 8]),
            .c1             (cfg.color_one[16-8*k +: 8]),
            .kc             (cfg.konst_color[16-8*k +: 8]),
            .g              (cfg.tint_color[16-8*k +: 8]),
            .tex_chan       (tex_rgb[k]),
            .tex_alpha      (tex_alpha),
            .out_chan       (out_rgb[k])
        );
    end

    tev_alpha_path u_alpha (
        .clk          (clk),
        .ctrl         (ctrl),
        .combine_mode (cfg.combine_mode),
        .konst_alpha  (cfg.konst_alpha),
        .tex_alpha    (tex_alpha),
        .out_alpha    (out_alpha)
    );

    assign out_red   = out_rgb[0];
    assign out_green = out_rgb[1];
    assign out_blue  = out_rgb[2];

endmodule
